FILE: src/stt_pkg.sv
`default_nettype none

package stt_pkg;

  localparam int FIELD_W       = 20;
  localparam int KIND_W        = 5;
  localparam int LINE_W        = 20;
  localparam int POS_BITS_DEF  = 20;
  localparam int NEST_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STRING = 5'd2;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd9;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [LINE_W-1:0]  line;
    logic               last;
  } token_t;

  // {hit, kind} for the single-character punctuation tokens
  function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
    logic [KIND_W:0] r;
    begin
      case (c)
        8'h2C:   r = {1'b1, 5'd4};
        8'h2E:   r = {1'b1, 5'd5};
        8'h3B:   r = {1'b1, 5'd6};
        8'h3A:   r = {1'b1, 5'd7};
        8'h2B:   r = {1'b1, 5'd8};
        8'h2D:   r = {1'b1, 5'd9};
        8'h2A:   r = {1'b1, 5'd10};
        8'h2F:   r = {1'b1, 5'd11};
        8'h24:   r = {1'b1, 5'd12};
        8'h40:   r = {1'b1, 5'd13};
        8'h3D:   r = {1'b1, 5'd14};
        8'h28:   r = {1'b1, 5'd15};
        8'h29:   r = {1'b1, 5'd16};
        8'h7B:   r = {1'b1, 5'd17};
        8'h7D:   r = {1'b1, 5'd18};
        8'h5B:   r = {1'b1, 5'd19};
        8'h5D:   r = {1'b1, 5'd20};
        8'h3C:   r = {1'b1, 5'd21};
        8'h3E:   r = {1'b1, 5'd22};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

FILE: src/source_text_tokenizer_top.sv
// Streaming source lexer: takes one source byte per beat and returns tokens (identifier,
// number, string, char with start offset and length, plus nineteen punctuation kinds)
// tagged with the current line. Every byte is decoded in the cycle it is accepted, so
// input runs at one byte per clock; a byte may close one token and open another, giving
// two output beats, and a four-entry result queue lets input continue while those drain.
// in_ready drops only when the queue cannot hold two more tokens. A byte with
// end_of_text set flushes any open token and returns the lexer to its reset state.
`default_nettype none

module source_text_tokenizer_top
  import stt_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int NEST_BITS = NEST_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         text_byte,
  input  wire logic               end_of_text,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       token_kind,
  output logic [FIELD_W-1:0]      text_start,
  output logic [FIELD_W-1:0]      text_length,
  output logic [LINE_W-1:0]       line_number,
  output logic                    run_last
);

  localparam int WIDE_W = (POS_BITS > FIELD_W) ? POS_BITS : FIELD_W;

  localparam logic [1:0] MM_NONE = 2'd0;
  localparam logic [1:0] MM_Q    = 2'd1;
  localparam logic [1:0] MM_QQ   = 2'd2;
  localparam logic [1:0] MM_BAR  = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_CHAR, M_MINUS,
    M_BAR, M_BARQ, M_LINE, M_BLOCK, M_BLOCK_BQ
  } mode_t;

  function automatic logic [FIELD_W-1:0] clip_pos(input logic [POS_BITS-1:0] v);
    logic [WIDE_W-1:0] w;
    begin
      w = WIDE_W'(v);
      return ((w >> FIELD_W) != '0) ? '1 : w[FIELD_W-1:0];
    end
  endfunction

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
    return (v == '1) ? v : v + POS_BITS'(1);
  endfunction

  mode_t                mode, mode_next;
  logic [POS_BITS-1:0]  byte_position;
  logic [LINE_W-1:0]    line_count;
  logic [POS_BITS-1:0]  token_start, token_start_next;
  logic [NEST_BITS-1:0] comment_depth, comment_depth_next;
  logic [NEST_BITS-1:0] depth_dec;
  logic [1:0]           marker_match, marker_match_next;

  logic                 accept;
  logic [POS_BITS-1:0]  end_pos;
  logic                 line_inc;
  logic                 run_idle;
  logic [KIND_W:0]      punct;
  logic                 emit_a, emit_b, emit_c;
  logic [KIND_W-1:0]    kind_a, kind_c;
  logic [POS_BITS-1:0]  start_a, len_a, start_c, len_c;
  token_t               tok_a, tok_b, tok_c, tok_first, tok_second;
  logic [1:0]           n_tokens;
  logic [1:0]           push_count;
  logic                 room;
  token_t               head;

  assign accept  = in_valid && in_ready;
  assign end_pos = pos_inc(byte_position);
  assign punct   = punct_lookup(text_byte);

  always_comb begin
    mode_next          = mode;
    token_start_next   = token_start;
    comment_depth_next = comment_depth;
    marker_match_next  = marker_match;
    depth_dec          = (comment_depth != '0) ? comment_depth - NEST_BITS'(1) : comment_depth;
    line_inc           = 1'b0;
    run_idle           = 1'b0;
    emit_a             = 1'b0;
    emit_b             = 1'b0;
    emit_c             = 1'b0;
    kind_a             = KIND_IDENT;
    kind_c             = KIND_IDENT;
    start_a            = '0;
    len_a              = '0;
    start_c            = '0;
    len_c              = '0;

    case (mode)
      M_IDENT, M_NUMBER: begin
        if (!(is_digit(text_byte) || (mode == M_IDENT && is_alpha(text_byte)))) begin
          emit_a   = 1'b1;
          kind_a   = (mode == M_IDENT) ? KIND_IDENT : KIND_NUMBER;
          start_a  = token_start;
          len_a    = byte_position - token_start;
          run_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (text_byte == CH_DQUOTE) begin
          emit_a    = 1'b1;
          kind_a    = KIND_STRING;
          start_a   = token_start;
          len_a     = byte_position - token_start;
          mode_next = M_IDLE;
        end
      end
      M_CHAR: begin
        if (text_byte == CH_SQUOTE) begin
          emit_a    = 1'b1;
          kind_a    = KIND_CHAR;
          start_a   = token_start;
          len_a     = byte_position - token_start;
          mode_next = M_IDLE;
        end
      end
      M_MINUS: begin
        if (text_byte == CH_MINUS) begin
          mode_next = M_LINE;
        end else begin
          emit_a   = 1'b1;
          kind_a   = KIND_MINUS;
          run_idle = 1'b1;
        end
      end
      M_BAR: begin
        if (text_byte == CH_DQUOTE) begin
          mode_next = M_BARQ;
        end else begin
          run_idle = 1'b1;
        end
      end
      M_BARQ: begin
        if (text_byte == CH_DQUOTE) begin
          mode_next          = M_BLOCK;
          comment_depth_next = NEST_BITS'(1);
          marker_match_next  = MM_Q;
        end else begin
          mode_next        = M_STRING;
          token_start_next = byte_position;
        end
      end
      M_LINE: begin
        if (text_byte == CH_NL) begin
          line_inc  = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_BLOCK_BQ: begin
        line_inc  = (text_byte == CH_NL);
        mode_next = M_BLOCK;
        if (text_byte == CH_DQUOTE) begin
          if (comment_depth != '1) begin
            comment_depth_next = comment_depth + NEST_BITS'(1);
          end
          marker_match_next = MM_Q;
        end else begin
          marker_match_next = (text_byte == CH_BAR) ? MM_BAR : MM_NONE;
        end
      end
      M_BLOCK: begin
        line_inc = (text_byte == CH_NL);
        if (text_byte == CH_BAR) begin
          marker_match_next = MM_BAR;
          if (marker_match == MM_QQ) begin
            comment_depth_next = depth_dec;
            if (depth_dec == '0) begin
              mode_next         = M_IDLE;
              marker_match_next = MM_NONE;
            end
          end
        end else if (text_byte == CH_DQUOTE) begin
          if (marker_match == MM_BAR) begin
            mode_next         = M_BLOCK_BQ;
            marker_match_next = MM_NONE;
          end else begin
            marker_match_next = (marker_match == MM_NONE) ? MM_Q : MM_QQ;
          end
        end else begin
          marker_match_next = MM_NONE;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_next = M_IDLE;
      if (is_space(text_byte)) begin
        line_inc = (text_byte == CH_NL);
      end else if (text_byte == CH_MINUS) begin
        mode_next = M_MINUS;
      end else if (text_byte == CH_BAR) begin
        mode_next = M_BAR;
      end else if (is_alpha(text_byte)) begin
        mode_next        = M_IDENT;
        token_start_next = byte_position;
      end else if (is_digit(text_byte)) begin
        mode_next        = M_NUMBER;
        token_start_next = byte_position;
      end else if (text_byte == CH_DQUOTE) begin
        mode_next        = M_STRING;
        token_start_next = end_pos;
      end else if (text_byte == CH_SQUOTE) begin
        mode_next        = M_CHAR;
        token_start_next = end_pos;
      end else begin
        emit_b = punct[KIND_W];
      end
    end

    // last byte: flush whatever the byte left open
    if (end_of_text) begin
      case (mode_next)
        M_IDENT: begin
          emit_c = 1'b1;
          kind_c = KIND_IDENT;
        end
        M_NUMBER: begin
          emit_c = 1'b1;
          kind_c = KIND_NUMBER;
        end
        M_STRING: begin
          emit_c = 1'b1;
          kind_c = KIND_STRING;
        end
        M_CHAR: begin
          emit_c = 1'b1;
          kind_c = KIND_CHAR;
        end
        M_MINUS: begin
          emit_c = 1'b1;
          kind_c = KIND_MINUS;
        end
        M_BARQ: begin
          emit_c = 1'b1;
          kind_c = KIND_STRING;
        end
        default: begin
          emit_c = 1'b0;
        end
      endcase
      if (mode_next == M_IDENT || mode_next == M_NUMBER || mode_next == M_STRING ||
          mode_next == M_CHAR) begin
        start_c = token_start_next;
        len_c   = end_pos - token_start_next;
      end else if (mode_next == M_BARQ) begin
        start_c = end_pos;
      end
    end
  end

  always_comb begin
    tok_a = '{kind: kind_a, start: clip_pos(start_a), length: clip_pos(len_a),
              line: line_count, last: 1'b0};
    tok_b = '{kind: punct[KIND_W-1:0], start: '0, length: '0,
              line: line_count, last: 1'b0};
    tok_c = '{kind: kind_c, start: clip_pos(start_c), length: clip_pos(len_c),
              line: line_count, last: 1'b0};
    n_tokens   = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
    tok_first  = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    tok_second = emit_b ? tok_b : tok_c;
    tok_first.last  = (n_tokens == 2'd1);
    tok_second.last = 1'b1;
    push_count = accept ? n_tokens : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      byte_position <= '0;
      line_count    <= LINE_W'(1);
      token_start   <= '0;
      comment_depth <= '0;
      marker_match  <= MM_NONE;
    end else if (accept) begin
      if (end_of_text) begin
        mode          <= M_IDLE;
        byte_position <= '0;
        line_count    <= LINE_W'(1);
        token_start   <= '0;
        comment_depth <= '0;
        marker_match  <= MM_NONE;
      end else begin
        mode          <= mode_next;
        byte_position <= end_pos;
        token_start   <= token_start_next;
        comment_depth <= comment_depth_next;
        marker_match  <= marker_match_next;
        if (line_inc && line_count != '1) begin
          line_count <= line_count + LINE_W'(1);
        end
      end
    end
  end

  stt_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (tok_first),
    .push_second (tok_second),
    .room        (room),
    .head        (head),
    .head_valid  (out_valid),
    .head_ready  (out_ready)
  );

  assign in_ready    = room;
  assign token_kind  = head.kind;
  assign text_start  = head.start;
  assign text_length = head.length;
  assign line_number = head.line;
  assign run_last    = head.last;

  a_depth_tracks_block: assert property (@(posedge clk) disable iff (rst)
    ((mode == M_BLOCK) || (mode == M_BLOCK_BQ)) == (comment_depth != '0))
    else $error("comment depth out of step with block comment mode");

  a_marker_only_in_block: assert property (@(posedge clk) disable iff (rst)
    (mode != M_BLOCK) |-> (marker_match == MM_NONE))
    else $error("marker progress held outside block comment");

  a_flush_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=>
      (mode == M_IDLE && byte_position == '0 && line_count == LINE_W'(1)))
    else $error("last byte did not return lexer to reset state");

  a_position_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !end_of_text) |=>
      (byte_position != '0 && byte_position >= $past(byte_position)))
    else $error("byte position failed to advance");

endmodule

`default_nettype wire

FILE: src/stt_queue.sv
`default_nettype none

module stt_queue
  import stt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_count,
  input  wire token_t     push_first,
  input  wire token_t     push_second,
  output logic            room,
  output token_t          head,
  output logic            head_valid,
  input  wire logic       head_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign room       = (count <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      count  <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + PTR_W'(1)] <= push_second;
    end
  end

endmodule

`default_nettype wire

FILE: verif/source_text_tokenizer_checker.sv
`timescale 1ns / 100ps

module source_text_tokenizer_checker
  import stt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [7:0]         text_byte,
  input  wire logic               end_of_text,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [KIND_W-1:0]  token_kind,
  input  wire logic [FIELD_W-1:0] text_start,
  input  wire logic [FIELD_W-1:0] text_length,
  input  wire logic [LINE_W-1:0]  line_number,
  input  wire logic               run_last,
  output int                      mismatches,
  output int                      tokens_pending,
  output int                      tokens_checked
);

  localparam int PUNCT_COUNT = 19;
  localparam int PUNCT_FIRST = 4;
  localparam int REPORT_CAP  = 40;
  localparam logic [8*PUNCT_COUNT-1:0] PUNCT_CHARS = ",.;:+-*/$@=(){}[]<>";

  typedef enum logic [3:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_CHAR, LX_MINUS,
    LX_BAR, LX_BARQ, LX_LINE, LX_BLOCK, LX_BLOCK_BQ
  } lex_mode_e;

  // progress toward a comment marker
  typedef enum logic [1:0] {MK_NONE, MK_Q, MK_QQ, MK_BAR} marker_e;

  lex_mode_e                mode;
  marker_e                  mark;
  logic [FIELD_W-1:0]       byte_pos;
  logic [FIELD_W-1:0]       tok_start;
  logic [LINE_W-1:0]        line_cnt;
  logic [NEST_BITS_DEF-1:0] depth;
  token_t                   byte_tokens [2];
  int                       n_byte_tokens;
  token_t                   tokens_due [$];

  function automatic logic is_letter(input logic [7:0] c);
    return (c == CH_UNDER) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    for (int k = 0; k < PUNCT_COUNT; k++) begin
      if (PUNCT_CHARS[8*(PUNCT_COUNT-1-k) +: 8] == c) return KIND_W'(PUNCT_FIRST + k);
    end
    return '0;
  endfunction

  function automatic logic [FIELD_W-1:0] next_pos(input logic [FIELD_W-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic void bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void clear_lexer();
    mode      = LX_IDLE;
    mark      = MK_NONE;
    byte_pos  = '0;
    tok_start = '0;
    line_cnt  = LINE_W'(1);
    depth     = '0;
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] k, input logic [FIELD_W-1:0] s,
                                    input logic [FIELD_W-1:0] len);
    if (n_byte_tokens < 2) begin
      byte_tokens[n_byte_tokens] = '{kind: k, start: s, length: len, line: line_cnt,
                                     last: 1'b0};
      n_byte_tokens++;
    end
  endfunction

  function automatic void idle_byte(input logic [7:0] c, input logic [FIELD_W-1:0] p);
    logic [KIND_W-1:0] k;
    k = punct_kind(c);
    if (is_blank(c)) begin
      if (c == CH_NL) bump_line();
    end else if (c == CH_MINUS) begin
      mode = LX_MINUS;
    end else if (c == CH_BAR) begin
      mode = LX_BAR;
    end else if (is_letter(c)) begin
      mode = LX_IDENT;
      tok_start = p;
    end else if (is_numeral(c)) begin
      mode = LX_NUMBER;
      tok_start = p;
    end else if (c == CH_DQUOTE) begin
      mode = LX_STRING;
      tok_start = next_pos(p);
    end else if (c == CH_SQUOTE) begin
      mode = LX_CHAR;
      tok_start = next_pos(p);
    end else if (k != '0) begin
      add_token(k, '0, '0);
    end
  endfunction

  // a marker's third byte may begin the next marker
  function automatic void block_byte(input logic [7:0] c);
    if (c == CH_NL) bump_line();
    if (mode == LX_BLOCK_BQ) begin
      mode = LX_BLOCK;
      if (c == CH_DQUOTE) begin
        if (depth != '1) depth = depth + 1'b1;
        mark = MK_Q;
      end else if (c == CH_BAR) begin
        mark = MK_BAR;
      end else begin
        mark = MK_NONE;
      end
    end else if (c == CH_BAR) begin
      if (mark == MK_QQ && depth != '0) depth = depth - 1'b1;
      if (mark == MK_QQ && depth == '0) begin
        mode = LX_IDLE;
        mark = MK_NONE;
      end else begin
        mark = MK_BAR;
      end
    end else if (c == CH_DQUOTE) begin
      if (mark == MK_BAR) begin
        mode = LX_BLOCK_BQ;
        mark = MK_NONE;
      end else if (mark == MK_NONE) begin
        mark = MK_Q;
      end else begin
        mark = MK_QQ;
      end
    end else begin
      mark = MK_NONE;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic [FIELD_W-1:0] p);
    case (mode)
      LX_IDENT, LX_NUMBER: begin
        if (!(is_numeral(c) || (mode == LX_IDENT && is_letter(c)))) begin
          add_token(mode == LX_IDENT ? KIND_IDENT : KIND_NUMBER, tok_start, p - tok_start);
          mode = LX_IDLE;
          idle_byte(c, p);
        end
      end
      LX_STRING: begin
        if (c == CH_DQUOTE) begin
          add_token(KIND_STRING, tok_start, p - tok_start);
          mode = LX_IDLE;
        end
      end
      LX_CHAR: begin
        if (c == CH_SQUOTE) begin
          add_token(KIND_CHAR, tok_start, p - tok_start);
          mode = LX_IDLE;
        end
      end
      LX_MINUS: begin
        if (c == CH_MINUS) begin
          mode = LX_LINE;
        end else begin
          add_token(KIND_MINUS, '0, '0);
          mode = LX_IDLE;
          idle_byte(c, p);
        end
      end
      LX_BAR: begin
        if (c == CH_DQUOTE) begin
          mode = LX_BARQ;
        end else begin
          mode = LX_IDLE;
          idle_byte(c, p);
        end
      end
      LX_BARQ: begin
        if (c == CH_DQUOTE) begin
          mode  = LX_BLOCK;
          depth = NEST_BITS_DEF'(1);
          mark  = MK_Q;
        end else begin
          mode = LX_STRING;
          tok_start = p;
        end
      end
      LX_LINE: begin
        if (c == CH_NL) begin
          bump_line();
          mode = LX_IDLE;
        end
      end
      LX_BLOCK, LX_BLOCK_BQ: block_byte(c);
      default: idle_byte(c, p);
    endcase
  endfunction

  function automatic void flush_text(input logic [FIELD_W-1:0] endp);
    case (mode)
      LX_IDENT:  add_token(KIND_IDENT, tok_start, endp - tok_start);
      LX_NUMBER: add_token(KIND_NUMBER, tok_start, endp - tok_start);
      LX_STRING: add_token(KIND_STRING, tok_start, endp - tok_start);
      LX_CHAR:   add_token(KIND_CHAR, tok_start, endp - tok_start);
      LX_MINUS:  add_token(KIND_MINUS, '0, '0);
      LX_BARQ:   add_token(KIND_STRING, endp, '0);
      default: ;
    endcase
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic eot);
    logic [FIELD_W-1:0] p;
    p = byte_pos;
    n_byte_tokens = 0;
    scan_byte(c, p);
    if (eot) begin
      flush_text(next_pos(p));
      clear_lexer();
    end else begin
      byte_pos = next_pos(p);
    end
    for (int i = 0; i < n_byte_tokens; i++) begin
      byte_tokens[i].last = (i == n_byte_tokens - 1);
      tokens_due.push_back(byte_tokens[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      clear_lexer();
      tokens_due.delete();
      mismatches = 0;
      tokens_checked = 0;
    end else begin
      if (in_valid && in_ready) lex_byte(text_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          if (mismatches < REPORT_CAP) $error("token of kind %0d with none due", token_kind);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", want.kind, token_kind);
          check_field("text_start", want.start, text_start);
          check_field("text_length", want.length, text_length);
          check_field("line_number", want.line, line_number);
          check_field("run_last", want.last, run_last);
          tokens_checked++;
        end
      end
    end
    tokens_pending <= tokens_due.size();
  end

endmodule

FILE: verif/source_text_tokenizer_top_test.sv
`timescale 1ns / 100ps

module source_text_tokenizer_top_test;
  import stt_pkg::*;

  localparam int PUNCT_COUNT  = 19;
  localparam int PHASE_ITEMS  = 265;
  localparam int NEST_OPENERS = 3;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [8*PUNCT_COUNT-1:0] PUNCT_CHARS = ",.;:+-*/$@=(){}[]<>";

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         text_byte = '0;
  logic               end_of_text = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  token_kind;
  logic [FIELD_W-1:0] text_start;
  logic [FIELD_W-1:0] text_length;
  logic [LINE_W-1:0]  line_number;
  logic               run_last;

  int         mismatches;
  int         tokens_pending;
  int         tokens_checked;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         bytes_sent = 0;
  int         texts_sent = 0;
  logic [7:0] frag [$];

  source_text_tokenizer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .text_start (text_start),
    .text_length(text_length),
    .line_number(line_number),
    .run_last   (run_last)
  );

  source_text_tokenizer_checker token_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .text_start    (text_start),
    .text_length   (text_length),
    .line_number   (line_number),
    .run_last      (run_last),
    .mismatches    (mismatches),
    .tokens_pending(tokens_pending),
    .tokens_checked(tokens_checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] any_punct();
    return PUNCT_CHARS[8*$urandom_range(PUNCT_COUNT-1) +: 8];
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] literal_byte(input logic [7:0] closing);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == closing) ? CH_NL : c;
  endfunction

  // weighted toward marker bytes so partial and overlapping markers show up
  function automatic logic [7:0] comment_byte();
    case ($urandom_range(5))
      0, 1: return CH_DQUOTE;
      2: return CH_BAR;
      3: return CH_NL;
      4: return any_letter();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endfunction

  // returns 1 for fragment kinds built to carry tokens, 0 for blanks, comments and random bytes
  function automatic bit build_fragment();
    int sel;
    int n;
    int nest;
    frag.delete();
    sel = $urandom_range(99);
    n = $urandom_range(1, 5);
    if (sel < 18) begin
      frag.push_back(any_letter());
      repeat (n - 1) frag.push_back($urandom_range(2) == 0 ? any_digit() : any_letter());
    end else if (sel < 30) begin
      repeat (n) frag.push_back(any_digit());
    end else if (sel < 38) begin
      frag.push_back(CH_DQUOTE);
      repeat (n - 1) frag.push_back(literal_byte(CH_DQUOTE));
      frag.push_back(CH_DQUOTE);
    end else if (sel < 44) begin
      frag.push_back(CH_SQUOTE);
      repeat ($urandom_range(2)) frag.push_back(literal_byte(CH_SQUOTE));
      frag.push_back(CH_SQUOTE);
    end else if (sel < 56) begin
      repeat ($urandom_range(1, 2)) frag.push_back(any_punct());
    end else if (sel < 64) begin
      repeat (n) frag.push_back(any_blank());
      return 0;
    end else if (sel < 69) begin
      push_text("--");
      repeat (n) frag.push_back(literal_byte(CH_NL));
      frag.push_back(CH_NL);
      return 0;
    end else if (sel < 77) begin
      push_text("|\"\"");
      nest = 1;
      repeat (2 * n) begin
        case ($urandom_range(9))
          0: begin
            push_text("|\"\"");
            nest++;
          end
          1: begin
            if (nest > 1) begin
              push_text("\"\"|");
              nest--;
            end
          end
          default: frag.push_back(comment_byte());
        endcase
      end
      repeat (nest) push_text("\"\"|");
      return 0;
    end else if (sel < 83) begin
      frag.push_back(CH_BAR);
      case ($urandom_range(2))
        0: frag.push_back($urandom_range(1) ? any_letter() : any_punct());
        1: begin
          frag.push_back(CH_DQUOTE);
          repeat (n) frag.push_back(literal_byte(CH_DQUOTE));
          frag.push_back(CH_DQUOTE);
        end
        default: frag.push_back(CH_DQUOTE);
      endcase
    end else if (sel < 89) begin
      frag.push_back(CH_MINUS);
      case ($urandom_range(3))
        0: frag.push_back(any_digit());
        1: frag.push_back(any_letter());
        2: frag.push_back(any_punct());
        default: frag.push_back(any_blank());
      endcase
    end else begin
      repeat (n) frag.push_back(8'($urandom_range(255)));
      return 0;
    end
    return 1;
  endfunction

  // valid stays up across back-to-back beats, so it is only lowered before a gap
  task automatic send_byte(input logic [7:0] c, input logic eot);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    text_byte   <= c;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (frag[i]) send_byte(frag[i], i == frag.size() - 1);
    texts_sent++;
  endtask

  // now and then the text ends on this fragment, sometimes cut short
  task automatic send_fragment();
    int ending;
    int cut;
    ending = $urandom_range(29);
    cut = (ending == 0) ? $urandom_range(frag.size() - 1) : frag.size() - 1;
    for (int i = 0; i <= cut; i++) send_byte(frag[i], ending <= 2 && i == cut);
    if (ending <= 2) texts_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct);
    int counted;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      void'(build_fragment());
      counted += frag.size();
      send_fragment();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 65;

    // punctuation, token ends, lone bar, bar-quote string holding raw bytes
    frag.delete();
    push_text("_Z9,.;:+-*/$@=(){}[]<>|x|\"");
    frag.push_back(8'hFF);
    frag.push_back(CH_NL);
    frag.push_back(8'h00);
    frag.push_back(CH_SQUOTE);
    send_text();
    frag.delete();
    push_text("|\"");
    send_text();
    frag.delete();
    push_text("9-");
    send_text();

    // nested openers, then an unterminated comment
    frag.delete();
    repeat (NEST_OPENERS) push_text("|\"\"");
    push_text("\"\"|\"\"|x\n");
    send_text();

    run_phase(6, 65);
    run_phase(65, 6);
    run_phase(0, 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d texts, %0d tokens compared", bytes_sent, texts_sent,
             tokens_checked);
    $display("nested comments, flushes at end of text, and three idling mixes included");
    if (tokens_pending != 0) $error("%0d tokens never arrived", tokens_pending);
    if (mismatches == 0 && tokens_pending == 0) begin
      $display("source_text_tokenizer_top verification clean");
    end else begin
      $display("source_text_tokenizer_top verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("source_text_tokenizer_top verification failed");
    $finish;
  end

endmodule
